/* rtl/min_error_boundary_cut_seam_assert.svh */
// assertion macros shared by the seam cut modules
`ifndef MIN_ERROR_BOUNDARY_CUT_SEAM_ASSERT_SVH
`define MIN_ERROR_BOUNDARY_CUT_SEAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define MEBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEBC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) expr) else $error(msg);
`else
`define MEBC_ASSERT(label, prop, msg)
`define MEBC_ASSERT_ALWAYS(label, expr, msg)
`endif
`endif

/* rtl/mebc_pkg.sv */
package mebc_pkg;

    // fixed field widths
    localparam int PIX_W   = 8;
    localparam int ERR_W   = 18;
    localparam int COST_W  = 24;
    localparam int ROW_O_W = 6;
    localparam int COL_O_W = 4;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 40;

    // configuration registers
    localparam int PR_W    = 7;
    localparam int OC_W    = 5;
    localparam int CU_W    = 3;
    localparam int SLACK_W = 20;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_PATCH_ROWS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_OVERLAP_COLS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNELS_USED = 2'd2;
    localparam logic [IDX_W-1:0] REG_SLACK         = 2'd3;

    localparam logic [PR_W-1:0]    RST_PATCH_ROWS    = 7'd50;
    localparam logic [OC_W-1:0]    RST_OVERLAP_COLS  = 5'd8;
    localparam logic [CU_W-1:0]    RST_CHANNELS_USED = 3'd3;
    localparam logic [SLACK_W-1:0] RST_SLACK         = 20'd651;

    // default sizes
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLS     = 16;
    localparam int DEF_MAX_CHANNELS = 4;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic calc;
        logic sel_rd;
        logic sel_cmp;
        logic emit;
        logic tr_rd0;
        logic tr_rd1;
        logic tr_min;
        logic tr_pick;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_pixel;
        logic sel_last;
        logic trace_end;
        logic out_free;
    } status_t;

endpackage

/* rtl/min_error_boundary_cut_seam.sv */
// pixel load: each item gets error capture, then path-cost update into the cost RAM, before the next is taken
// after the last pixel: a read and a compare per column pick the bottom column, first result follows
// each further row: three neighbour reads over two RAM ports, min, pick, emit
// a waiting result does not block the next run's first pixel
// rst_n is asynchronous, active low; registers return to 50, 8, 3, 651, no RAM clear
module min_error_boundary_cut_seam
#(
    parameter int MAX_ROWS     = mebc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = mebc_pkg::DEF_MAX_COLS,
    parameter int MAX_CHANNELS = mebc_pkg::DEF_MAX_CHANNELS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // ref_c0, ref_c1, ref_c2, ref_c3, cand_c0, cand_c1, cand_c2, cand_c3
    input  logic [mebc_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // row_index, seam_col, seam_cost, zero pad
    output logic [mebc_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [mebc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [mebc_pkg::CFG_W-1:0]  cfg_data
);

    mebc_pkg::cmd_t    cmd;
    mebc_pkg::status_t status;

    // sequencer
    mebc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // cost datapath
    mebc_dp
    #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/mebc_ctrl.sv */
module mebc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  mebc_pkg::status_t status,
    output mebc_pkg::cmd_t   cmd
);

    `include "min_error_boundary_cut_seam_assert.svh"

    localparam logic [3:0] S_IN      = 4'd0;
    localparam logic [3:0] S_CALC    = 4'd1;
    localparam logic [3:0] S_SEL_RD  = 4'd2;
    localparam logic [3:0] S_SEL_CMP = 4'd3;
    localparam logic [3:0] S_EMIT    = 4'd4;
    localparam logic [3:0] S_TR0     = 4'd5;
    localparam logic [3:0] S_TR1     = 4'd6;
    localparam logic [3:0] S_TR2     = 4'd7;
    localparam logic [3:0] S_TR3     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IN);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IN:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = status.last_pixel ? S_SEL_RD : S_IN;
            end
            S_SEL_RD:
            begin
                cmd.sel_rd = 1'b1;
                state_next = S_SEL_CMP;
            end
            S_SEL_CMP:
            begin
                cmd.sel_cmp = 1'b1;
                state_next  = status.sel_last ? S_EMIT : S_SEL_RD;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.trace_end ? S_IN : S_TR0;
                end
            end
            S_TR0:
            begin
                cmd.tr_rd0 = 1'b1;
                state_next = S_TR1;
            end
            S_TR1:
            begin
                cmd.tr_rd1 = 1'b1;
                state_next = S_TR2;
            end
            S_TR2:
            begin
                cmd.tr_min = 1'b1;
                state_next = S_TR3;
            end
            S_TR3:
            begin
                cmd.tr_pick = 1'b1;
                state_next  = S_EMIT;
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IN;
        else
            state_reg <= state_next;
    end

    `MEBC_ASSERT(a_accept_to_calc, (s_tvalid && s_tready) |=> (state_reg == S_CALC), "accepted item not followed by cost update")
    `MEBC_ASSERT(a_emit_free, cmd.emit |-> status.out_free, "result loaded over a waiting result")
    `MEBC_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command")

endmodule

/* rtl/mebc_dp.sv */
module mebc_dp
#(
    parameter int MAX_ROWS     = mebc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = mebc_pkg::DEF_MAX_COLS,
    parameter int MAX_CHANNELS = mebc_pkg::DEF_MAX_CHANNELS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mebc_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mebc_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [mebc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [mebc_pkg::CFG_W-1:0]  cfg_data,
    input  mebc_pkg::cmd_t              cmd,
    output mebc_pkg::status_t           status
);

    `include "min_error_boundary_cut_seam_assert.svh"

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CH_HI = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;
    localparam int CW_ = mebc_pkg::COST_W;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
    endfunction

    // configuration
    logic [mebc_pkg::PR_W-1:0]    patch_rows_reg;
    logic [mebc_pkg::OC_W-1:0]    overlap_cols_reg;
    logic [mebc_pkg::CU_W-1:0]    channels_used_reg;
    logic [mebc_pkg::SLACK_W-1:0] slack_reg;
    logic [RW-1:0]                rows_eff;
    logic [CW-1:0]                cols_eff;
    logic [2:0]                   chans_eff;

    // load phase
    logic [RW-1:0]                row_reg;
    logic [CW-1:0]                col_reg;
    logic [mebc_pkg::ERR_W-1:0]   err_reg;
    logic [mebc_pkg::ERR_W-1:0]   err_next;
    logic [CW_-1:0]               winl_reg;
    logic [CW_-1:0]               cost_next;

    // path cost memory
    logic [CW_-1:0]               cost_mem [DEPTH];
    logic [AW-1:0]                addr_a;
    logic [AW-1:0]                addr_b;
    logic [CW_-1:0]               rda_reg;
    logic [CW_-1:0]               rdb_reg;

    // select and trace
    logic [CW-1:0]                j_reg;
    logic [CW_-1:0]               best_reg;
    logic [CW-1:0]                bi_reg;
    logic [CW-1:0]                p_reg;
    logic [RW-1:0]                trow_reg;
    logic [CW_-1:0]               total_reg;
    logic [CW_-1:0]               l_reg;
    logic [CW_-1:0]               m_reg;
    logic [CW_-1:0]               r_reg;
    logic [CW_-1:0]               vmin_reg;
    logic [CW-1:0]                amin_reg;
    logic                         sel_take;
    logic [CW-1:0]                sel_bi;
    logic [CW_-1:0]               sel_best;
    logic                         lv;
    logic                         rv;
    logic [CW-1:0]                p_dn;
    logic [CW-1:0]                p_up;

    // output register
    logic                         out_valid_reg;
    logic [mebc_pkg::ROW_O_W-1:0] out_row_reg;
    logic [mebc_pkg::COL_O_W-1:0] out_col_reg;
    logic [CW_-1:0]               out_cost_reg;
    logic                         out_last_reg;

    // clamp the row, column and channel registers into their ranges
    always_comb
    begin
        if (32'(patch_rows_reg) < 2)
            rows_eff = RW'(2);
        else if (32'(patch_rows_reg) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(patch_rows_reg);
        if (32'(overlap_cols_reg) < 1)
            cols_eff = CW'(1);
        else if (32'(overlap_cols_reg) > MAX_COLS)
            cols_eff = CW'(MAX_COLS);
        else
            cols_eff = CW'(overlap_cols_reg);
        if (32'(channels_used_reg) < 1)
            chans_eff = 3'd1;
        else if (32'(channels_used_reg) > CH_HI)
            chans_eff = 3'(CH_HI);
        else
            chans_eff = channels_used_reg;
    end

    // squared error over the active channels
    always_comb
    begin
        logic [17:0] d;
        logic [17:0] sq;
        err_next = '0;
        for (int c = 0; c < 4; c++)
        begin
            // square taken modulo 2^18 is exact, it never exceeds 65025
            d  = 18'(s_tdata[8*c +: 8]) - 18'(s_tdata[32 + 8*c +: 8]);
            sq = d * d;
            if (c < CH_HI && 3'(c) < chans_eff)
                err_next = err_next + sq;
        end
    end

    // path cost of the current pixel
    always_comb
    begin
        logic [CW_-1:0] best;
        best = rda_reg;
        if (col_reg != '0 && winl_reg < best)
            best = winl_reg;
        if ((CW+1)'(col_reg) + (CW+1)'(1) < (CW+1)'(cols_eff) && rdb_reg < best)
            best = rdb_reg;
        if (row_reg == '0)
            cost_next = CW_'(err_reg);
        else
            cost_next = CW_'(err_reg) + best;
    end

    // trace neighbours
    assign lv   = (p_reg != '0);
    assign rv   = ((CW+1)'(p_reg) + (CW+1)'(1) < (CW+1)'(cols_eff));
    assign p_dn = lv ? p_reg - CW'(1) : p_reg;
    assign p_up = rv ? p_reg + CW'(1) : p_reg;

    // read addresses
    always_comb
    begin
        logic [RW-1:0] up_row;
        up_row = (row_reg == '0) ? '0 : row_reg - RW'(1);
        addr_a = cell_addr(up_row, col_reg);
        addr_b = cell_addr(up_row, col_reg);
        if (cmd.capture)
        begin
            addr_a = cell_addr(up_row, col_reg);
            addr_b = cell_addr(up_row, ((CW+1)'(col_reg) + (CW+1)'(1) < (CW+1)'(cols_eff))
                                  ? col_reg + CW'(1) : col_reg);
        end
        else if (cmd.sel_rd)
            addr_a = cell_addr(rows_eff - RW'(1), j_reg);
        else if (cmd.tr_rd0)
        begin
            addr_a = cell_addr(trow_reg, p_dn);
            addr_b = cell_addr(trow_reg, p_reg);
        end
        else if (cmd.tr_rd1)
            addr_a = cell_addr(trow_reg, p_up);
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
            cost_mem[cell_addr(row_reg, col_reg)] <= cost_next;
        rda_reg <= cost_mem[addr_a];
        rdb_reg <= cost_mem[addr_b];
    end

    // bottom column select
    assign sel_take = (j_reg == '0) || (rda_reg < best_reg);
    assign sel_bi   = sel_take ? j_reg : bi_reg;
    assign sel_best = sel_take ? rda_reg : best_reg;

    // configuration and load counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_rows_reg    <= mebc_pkg::RST_PATCH_ROWS;
            overlap_cols_reg  <= mebc_pkg::RST_OVERLAP_COLS;
            channels_used_reg <= mebc_pkg::RST_CHANNELS_USED;
            slack_reg         <= mebc_pkg::RST_SLACK;
            row_reg           <= '0;
            col_reg           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mebc_pkg::REG_PATCH_ROWS:    patch_rows_reg    <= cfg_data[mebc_pkg::PR_W-1:0];
                mebc_pkg::REG_OVERLAP_COLS:  overlap_cols_reg  <= cfg_data[mebc_pkg::OC_W-1:0];
                mebc_pkg::REG_CHANNELS_USED: channels_used_reg <= cfg_data[mebc_pkg::CU_W-1:0];
                mebc_pkg::REG_SLACK:         slack_reg         <= cfg_data;
                default:                     slack_reg         <= slack_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.calc)
        begin
            if (col_reg == cols_eff - CW'(1))
            begin
                col_reg <= '0;
                row_reg <= status.last_pixel ? '0 : row_reg + RW'(1);
            end
            else
                col_reg <= col_reg + CW'(1);
        end
    end

    // payload registers of the load, select, trace and emit steps
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            err_reg <= err_next;
        if (cmd.calc)
            winl_reg <= rda_reg;
        if (cmd.sel_cmp)
        begin
            best_reg  <= sel_best;
            bi_reg    <= sel_bi;
            p_reg     <= sel_bi;
            total_reg <= sel_best;
            trow_reg  <= rows_eff - RW'(1);
        end
        if (cmd.emit)
            trow_reg <= trow_reg - RW'(1);
        if (cmd.tr_rd1)
        begin
            l_reg <= rda_reg;
            m_reg <= rdb_reg;
        end
        if (cmd.tr_min)
        begin
            logic [CW_-1:0] vm;
            logic [CW-1:0]  am;
            vm = m_reg;
            am = p_reg;
            if (lv)
            begin
                vm = l_reg;
                am = p_dn;
                if (m_reg < vm)
                begin
                    vm = m_reg;
                    am = p_reg;
                end
            end
            if (rv && rda_reg < vm)
            begin
                vm = rda_reg;
                am = p_up;
            end
            r_reg    <= rda_reg;
            vmin_reg <= vm;
            amin_reg <= am;
        end
        if (cmd.tr_pick)
        begin
            if (lv && (l_reg - vmin_reg) < CW_'(slack_reg))
                p_reg <= p_dn;
            else if ((m_reg - vmin_reg) < CW_'(slack_reg))
                p_reg <= p_reg;
            else if (rv && (r_reg - vmin_reg) < CW_'(slack_reg))
                p_reg <= p_up;
            else
                p_reg <= amin_reg;
        end
        if (cmd.emit)
        begin
            out_row_reg  <= mebc_pkg::ROW_O_W'(trow_reg);
            out_col_reg  <= mebc_pkg::COL_O_W'(p_reg);
            out_cost_reg <= total_reg;
            out_last_reg <= (trow_reg == '0);
        end
    end

    // sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_reg <= '0;
        else if (cmd.calc)
            j_reg <= '0;
        else if (cmd.sel_cmp)
            j_reg <= j_reg + CW'(1);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign status.last_pixel = (row_reg == rows_eff - RW'(1)) && (col_reg == cols_eff - CW'(1));
    assign status.sel_last   = (j_reg == cols_eff - CW'(1));
    assign status.trace_end  = (trow_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_cost_reg, out_col_reg, out_row_reg};

    `MEBC_ASSERT(a_col_in_range, (col_reg < cols_eff), "load column beyond strip width")
    `MEBC_ASSERT(a_seam_in_strip, m_tvalid |-> (32'(out_col_reg) < 32'(cols_eff)), "seam column outside strip")
    `MEBC_ASSERT(a_last_row0, (m_tvalid && m_tlast) |-> (out_row_reg == '0), "run ends on a row other than row 0")

endmodule

/* sim/tb_min_error_boundary_cut_seam.sv */
`timescale 1ns / 1ps

module tb_min_error_boundary_cut_seam;

    // one seam entry as it leaves the block
    typedef struct {
        bit [5:0]  row;
        bit [3:0]  col;
        bit [23:0] cost;
        bit        last;
    } seam_entry_t;

    // predicts seam entries from accepted pixels and checks what comes out
    class SeamScoreboard;
        bit [17:0]   err_mem [1024];
        bit [23:0]   cost_mem [1024];
        int unsigned pix_cnt;
        bit [6:0]    rows_r;
        bit [4:0]    cols_r;
        bit [2:0]    chans_r;
        bit [19:0]   slack_r;
        seam_entry_t pending [$];
        int          errors;

        function new();
            pix_cnt = 0;
            rows_r  = mebc_pkg::RST_PATCH_ROWS;
            cols_r  = mebc_pkg::RST_OVERLAP_COLS;
            chans_r = mebc_pkg::RST_CHANNELS_USED;
            slack_r = mebc_pkg::RST_SLACK;
            errors  = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // a register write also restarts the strip
        function void write_reg(logic [mebc_pkg::IDX_W-1:0] idx,
                                logic [mebc_pkg::CFG_W-1:0] v);
            case (idx)
                mebc_pkg::REG_PATCH_ROWS:    rows_r = v[mebc_pkg::PR_W-1:0];
                mebc_pkg::REG_OVERLAP_COLS:  cols_r = v[mebc_pkg::OC_W-1:0];
                mebc_pkg::REG_CHANNELS_USED: chans_r = v[mebc_pkg::CU_W-1:0];
                mebc_pkg::REG_SLACK:         slack_r = v[mebc_pkg::SLACK_W-1:0];
                default:                     return;
            endcase
            pix_cnt = 0;
        endfunction

        function void note_pixel(logic [mebc_pkg::IN_W-1:0] d);
            int          rows, cols, chans, total, row, col, dv, k, i, p;
            longint      err, best, cost, vmin, v, e_next, d_next, total_cost;
            bit          have, found;
            int          pick, amin;
            seam_entry_t ent;
            rows  = (rows_r < 2) ? 2 : (rows_r > 64) ? 64 : rows_r;
            cols  = (cols_r < 1) ? 1 : (cols_r > 16) ? 16 : cols_r;
            chans = (chans_r < 1) ? 1 : (chans_r > 4) ? 4 : chans_r;
            total = rows * cols;
            if (pix_cnt >= total)
                pix_cnt = 0;
            row = pix_cnt / cols;
            col = pix_cnt % cols;
            // squared channel differences
            err = 0;
            for (int c = 0; c < chans; c++)
            begin
                dv = int'(d[8*c +: 8]) - int'(d[32 + 8*c +: 8]);
                err += dv * dv;
            end
            // cheapest of the neighbours above
            cost = err;
            if (row > 0)
            begin
                have = 0;
                best = 0;
                for (k = col - 1; k <= col + 1; k++)
                begin
                    if (k < 0 || k >= cols)
                        continue;
                    v = cost_mem[(row - 1) * 16 + k];
                    if (!have || v < best)
                    begin
                        best = v;
                        have = 1;
                    end
                end
                cost = err + best;
            end
            err_mem[row * 16 + col]  = 18'(err);
            cost_mem[row * 16 + col] = 24'(cost);
            pix_cnt++;
            if (pix_cnt < total)
                return;
            pix_cnt = 0;
            // cheapest bottom column, lowest index on ties
            best = cost_mem[(rows - 1) * 16];
            p = 0;
            for (k = 1; k < cols; k++)
            begin
                v = cost_mem[(rows - 1) * 16 + k];
                if (v < best)
                begin
                    best = v;
                    p = k;
                end
            end
            total_cost = best & 24'hFFFFFF;
            ent.row = 6'(rows - 1);
            ent.col = 4'(p);
            ent.cost = 24'(total_cost);
            ent.last = 0;
            pending.push_back(ent);
            // trace upward, leftmost neighbour within slack, else cheapest
            for (i = rows - 2; i >= 0; i--)
            begin
                e_next = err_mem[(i + 1) * 16 + p];
                d_next = cost_mem[(i + 1) * 16 + p];
                found = 0;
                have = 0;
                pick = 0;
                amin = 0;
                vmin = 0;
                for (k = p - 1; k <= p + 1; k++)
                begin
                    if (k < 0 || k >= cols)
                        continue;
                    v = cost_mem[i * 16 + k];
                    if (!have || v < vmin)
                    begin
                        vmin = v;
                        amin = k;
                        have = 1;
                    end
                    if (!found && v + e_next - d_next < longint'(slack_r))
                    begin
                        pick = k;
                        found = 1;
                    end
                end
                p = found ? pick : amin;
                ent.row = 6'(i);
                ent.col = 4'(p);
                ent.cost = 24'(total_cost);
                ent.last = (i == 0);
                pending.push_back(ent);
            end
        endfunction

        task check(logic [mebc_pkg::OUT_W-1:0] d, logic l);
            seam_entry_t ent;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected seam entry %h", d));
                return;
            end
            ent = pending.pop_front();
            if (d[5:0] !== ent.row)
                report($sformatf("row_index %0d, want %0d", d[5:0], ent.row));
            if (d[9:6] !== ent.col)
                report($sformatf("seam_col %0d, want %0d (row %0d)", d[9:6], ent.col, ent.row));
            if (d[33:10] !== ent.cost)
                report($sformatf("seam_cost %0d, want %0d", d[33:10], ent.cost));
            if (l !== ent.last)
                report($sformatf("last %b, want %b (row %0d)", l, ent.last, ent.row));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mebc_pkg::IN_W-1:0]      s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mebc_pkg::OUT_W-1:0]     m_tdata;
    logic                           m_tlast;
    logic                           cfg_we;
    logic [mebc_pkg::IDX_W-1:0]     cfg_index;
    logic [mebc_pkg::CFG_W-1:0]     cfg_data;

    SeamScoreboard sb;
    bit            calm;
    int            hold_cycles;
    int            pixels_sent;

    min_error_boundary_cut_seam dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("tb_min_error_boundary_cut_seam: FAIL");
        $finish;
    end

    // result side: check, random stalls, one long hold-off on request
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check(m_tdata, m_tlast);
            if (hold_cycles > 0)
            begin
                m_tready <= 0;
                hold_cycles--;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // pixel content: 0 full random, 1 tiny values for ties, 2 extremes only
    function automatic logic [mebc_pkg::IN_W-1:0] make_pixel(int mode);
        logic [mebc_pkg::IN_W-1:0] d;
        d = {$urandom, $urandom};
        for (int b = 0; b < 8; b++)
        begin
            if (mode == 1)
                d[8*b +: 8] = 8'($urandom_range(3));
            else if (mode == 2)
                d[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return d;
    endfunction

    task send_pixel(logic [mebc_pkg::IN_W-1:0] d);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel(d);
        pixels_sent++;
    endtask

    task write_reg(logic [mebc_pkg::IDX_W-1:0] idx, logic [mebc_pkg::CFG_W-1:0] v);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task set_regs(int rows, int cols, int chans, int slack);
        write_reg(mebc_pkg::REG_PATCH_ROWS, mebc_pkg::CFG_W'(rows));
        write_reg(mebc_pkg::REG_OVERLAP_COLS, mebc_pkg::CFG_W'(cols));
        write_reg(mebc_pkg::REG_CHANNELS_USED, mebc_pkg::CFG_W'(chans));
        write_reg(mebc_pkg::REG_SLACK, mebc_pkg::CFG_W'(slack));
        cfg_we <= 0;
    endtask

    // stop offering, then wait for every seam entry and let the block settle
    task drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task send_pixels(int n, int mode);
        for (int i = 0; i < n; i++)
            send_pixel(make_pixel(mode));
    endtask

    initial
    begin
        int rows, cols, strip, runs;
        sb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 0;
        hold_cycles = 0;
        pixels_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // smallest strip, column count below range, slack zero
        set_regs(2, 0, 4, 0);
        send_pixel(64'h00000000_FFFFFFFF);
        send_pixel(64'hFFFFFFFF_00000000);
        send_pixel(64'h5A3C_0F81_5A3C_0F81);
        send_pixel(64'h0);
        drain();
        // rows and channels below range, widest slack, tiny values for ties
        set_regs(0, 3, 0, 20'hFFFFF);
        send_pixels(6, 1);
        drain();
        // rows and channels above range: tallest strip, one column
        set_regs(127, 1, 7, 0);
        send_pixels(64, 0);
        drain();
        // widest strip, channels above range, slack of one
        set_regs(2, 31, 5, 1);
        send_pixels(32, 1);
        send_pixels(32, 2);
        drain();

        // receiver holds off while several strips are offered; the block stalls on the waiting result
        set_regs(4, 2, 3, 300);
        hold_cycles = 400;
        send_pixels(32, 0);
        drain();

        // long stretch with no idling on either side
        calm = 1;
        set_regs(8, 8, 4, 651);
        send_pixels(64, 0);
        drain();
        calm = 0;

        // random settings; most strips complete, some cut short by the next write
        while (pixels_sent < 360)
        begin
            rows = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 2);
            cols = ($urandom_range(3) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
            // keep the item count near the target
            while (rows > 2 && rows * cols > 360 - pixels_sent)
                rows--;
            runs = (rows > 8) ? 1 : $urandom_range(3, 1);
            strip = rows * cols;
            case ($urandom_range(3))
                0: set_regs(rows, cols, $urandom_range(4, 1), 0);
                1: set_regs(rows, cols, $urandom_range(4, 1), $urandom_range(8));
                2: set_regs(rows, cols, $urandom_range(4, 1), $urandom_range(5000));
                default: set_regs(rows, cols, $urandom_range(4, 1), $urandom);
            endcase
            for (int r = 0; r < runs && pixels_sent < 360; r++)
                send_pixels(strip, $urandom_range(2));
            if (pixels_sent < 360 && strip > 1 && $urandom_range(3) == 0)
                send_pixels($urandom_range(strip - 1, 1), 0);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_min_error_boundary_cut_seam: PASS");
        else
            $display("tb_min_error_boundary_cut_seam: FAIL");
        $finish;
    end

endmodule
